// File: hdl/ale_pkg.sv
package ale_pkg;

	// field widths of the transaction
	localparam int FUNC_W = 4;
	localparam int IDX_W  = 7;
	localparam int VAL_W  = 32;
	localparam int DATA_W = 38;
	localparam int POS_W  = 6;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;
	localparam int CAP_W  = 7;

	// default store depth and capacity after reset
	localparam int DEPTH_DEF = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// data returned on a bad delete or get index
	localparam logic [DATA_W-1:0] DATA_NEG_ONE = '1;

	// operation codes
	typedef enum logic [FUNC_W-1:0] {
		F_APPEND     = 4'd0,
		F_INSERT     = 4'd1,
		F_DELETE     = 4'd2,
		F_SEARCH     = 4'd3,
		F_MOVE_FRONT = 4'd4,
		F_GET        = 4'd5,
		F_SET        = 4'd6,
		F_MAX        = 4'd7,
		F_MIN        = 4'd8,
		F_SUM        = 4'd9
	} func_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_BAD   = 2'd1,
		STAT_MISS  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	// shared unit operations
	typedef enum logic [2:0] {
		ALU_PASS,
		ALU_LOAD,
		ALU_MAX,
		ALU_MIN,
		ALU_ADD
	} alu_op_t;

	typedef struct packed {
		alu_op_t                  op;
		logic signed [DATA_W-1:0] acc;
		logic [VAL_W-1:0]         opnd;
	} alu_req_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_GET,
		S_INS_PUT,
		S_MF_SWAP,
		S_MF_FRONT
	} state_t;

endpackage

// File: hdl/array_list_engine.sv
// append, set, bad index, full, empty and unused codes strobe done in the cycle after start;
// get reads the store first; delete and insert move the entries from the index to the end,
// insert then writes the new value; search reads up to a match or the end, max/min/sum the whole list,
// and move-front then writes the old front entry to the match and the key to the front
// throughput: a new start is taken in the cycle done is shown; done lasts one cycle, no stall
// reset: entry count cleared, capacity set to 64, store contents undefined, no clearing pass
module array_list_engine #(
	parameter int DEPTH = ale_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              capacity_we,
	input  logic [ale_pkg::CAP_W-1:0]         capacity_data,
	input  logic                              start,
	input  logic [ale_pkg::FUNC_W-1:0]        func,
	input  logic [ale_pkg::IDX_W-1:0]         index,
	input  logic signed [ale_pkg::VAL_W-1:0]  value,
	output logic                              busy,
	output logic                              done,
	output logic signed [ale_pkg::DATA_W-1:0] data,
	output logic [ale_pkg::POS_W-1:0]         position,
	output logic [ale_pkg::STAT_W-1:0]        status,
	output logic [ale_pkg::CNT_W-1:0]         count
);
	import ale_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	// control registers
	state_t           state_q, state_d;
	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             done_q, done_d;
	logic             pv_q, pv_d;

	// operation and walk registers
	func_t                    func_q, func_d;
	logic [AW-1:0]            idx_q, idx_d;
	logic [VAL_W-1:0]         val_q, val_d;
	logic [CW-1:0]            left_q, left_d;
	logic [AW-1:0]            rp_q, rp_d;
	logic [AW-1:0]            pa_q, pa_d;
	logic signed [DATA_W-1:0] acc_q, acc_d;
	logic [VAL_W-1:0]         first_q, first_d;
	logic [AW-1:0]            hit_q, hit_d;

	// result registers
	logic signed [DATA_W-1:0] data_q, data_d;
	logic [AW-1:0]            pos_q, pos_d;
	status_t                  status_q, status_d;

	// store port
	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [VAL_W-1:0] mem_wdata, rdata;

	// shared unit
	alu_req_t                 alu_req;
	logic signed [DATA_W-1:0] alu_res;
	logic                     alu_hit;

	// start checks
	logic [XW-1:0] cap_x, lim_x, n_x, idx_x, nm1_x, diff_x, pos_x, cnt_x;
	logic          full, idx_gt, idx_ge, stop;

	assign cap_x  = XW'(cap_q);
	assign lim_x  = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
	assign n_x    = XW'(cnt_q);
	assign idx_x  = XW'(index);
	assign nm1_x  = n_x - 1'b1;
	assign diff_x = n_x - idx_x;
	assign full   = (n_x >= lim_x);
	assign idx_gt = (idx_x > n_x);
	assign idx_ge = (idx_x >= n_x);

	ale_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	ale_alu u_alu (
		.req(alu_req),
		.res(alu_res),
		.hit(alu_hit)
	);

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cap_q   <= CAP_RESET;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			pv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			pv_q    <= pv_d;
			if (capacity_we) begin
				cap_q <= capacity_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		func_q   <= func_d;
		idx_q    <= idx_d;
		val_q    <= val_d;
		left_q   <= left_d;
		rp_q     <= rp_d;
		pa_q     <= pa_d;
		acc_q    <= acc_d;
		first_q  <= first_d;
		hit_q    <= hit_d;
		data_q   <= data_d;
		pos_q    <= pos_d;
		status_q <= status_d;
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		done_d   = 1'b0;
		pv_d     = pv_q;
		func_d   = func_q;
		idx_d    = idx_q;
		val_d    = val_q;
		left_d   = left_q;
		rp_d     = rp_q;
		pa_d     = pa_q;
		acc_d    = acc_q;
		first_d  = first_q;
		hit_d    = hit_q;
		data_d   = data_q;
		pos_d    = pos_q;
		status_d = status_q;

		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;

		alu_req.op   = ALU_PASS;
		alu_req.acc  = acc_q;
		alu_req.opnd = rdata;
		stop         = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					func_d   = func_t'(func);
					idx_d    = idx_x[AW-1:0];
					val_d    = value;
					acc_d    = DATA_W'(value);
					pv_d     = 1'b0;
					data_d   = '0;
					pos_d    = '0;
					status_d = STAT_OK;
					case (func_t'(func))
						F_APPEND: begin
							done_d = 1'b1;
							if (full) begin
								status_d = STAT_BAD;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = n_x[AW-1:0];
								mem_wdata = value;
								cnt_d     = cnt_q + 1'b1;
							end
						end
						F_INSERT: begin
							if (full || idx_gt) begin
								done_d   = 1'b1;
								status_d = STAT_BAD;
							end else begin
								state_d = S_WALK;
								left_d  = diff_x[CW-1:0];
								rp_d    = nm1_x[AW-1:0];
							end
						end
						F_DELETE: begin
							if (idx_ge) begin
								done_d   = 1'b1;
								status_d = STAT_BAD;
								data_d   = DATA_NEG_ONE;
							end else begin
								state_d = S_WALK;
								left_d  = diff_x[CW-1:0];
								rp_d    = idx_x[AW-1:0];
							end
						end
						F_SEARCH, F_MOVE_FRONT: begin
							state_d = S_WALK;
							left_d  = cnt_q;
							rp_d    = '0;
						end
						F_GET: begin
							if (idx_ge) begin
								done_d   = 1'b1;
								status_d = STAT_BAD;
								data_d   = DATA_NEG_ONE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = idx_x[AW-1:0];
								state_d   = S_GET;
							end
						end
						F_SET: begin
							done_d = 1'b1;
							if (idx_ge) begin
								status_d = STAT_BAD;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = idx_x[AW-1:0];
								mem_wdata = value;
							end
						end
						F_MAX, F_MIN, F_SUM: begin
							if (cnt_q == '0) begin
								done_d   = 1'b1;
								status_d = STAT_EMPTY;
							end else begin
								state_d = S_WALK;
								left_d  = cnt_q;
								rp_d    = '0;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end

			S_WALK: begin
				// consume the entry read in the previous cycle
				if (pv_q) begin
					case (func_q)
						F_INSERT: begin
							mem_we    = 1'b1;
							mem_waddr = pa_q + 1'b1;
							mem_wdata = rdata;
						end
						F_DELETE: begin
							if (pa_q == idx_q) begin
								alu_req.op = ALU_LOAD;
								acc_d      = alu_res;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = pa_q - 1'b1;
								mem_wdata = rdata;
							end
						end
						F_SEARCH, F_MOVE_FRONT: begin
							if (pa_q == '0) begin
								first_d = rdata;
							end
							if (alu_hit) begin
								stop = 1'b1;
							end
						end
						F_MAX: begin
							alu_req.op = (pa_q == '0) ? ALU_LOAD : ALU_MAX;
							acc_d      = alu_res;
						end
						F_MIN: begin
							alu_req.op = (pa_q == '0) ? ALU_LOAD : ALU_MIN;
							acc_d      = alu_res;
						end
						F_SUM: begin
							alu_req.op = (pa_q == '0) ? ALU_LOAD : ALU_ADD;
							acc_d      = alu_res;
						end
						default: begin
							stop = 1'b0;
						end
					endcase
				end

				if (stop) begin
					// match found
					pv_d = 1'b0;
					if (func_q == F_MOVE_FRONT) begin
						hit_d   = pa_q;
						state_d = S_MF_SWAP;
					end else begin
						done_d   = 1'b1;
						data_d   = acc_q;
						pos_d    = pa_q;
						status_d = STAT_OK;
						state_d  = S_IDLE;
					end
				end else if (left_q != '0) begin
					// issue the next read
					mem_re    = 1'b1;
					mem_raddr = rp_q;
					rp_d      = (func_q == F_INSERT) ? rp_q - 1'b1 : rp_q + 1'b1;
					left_d    = left_q - 1'b1;
					pv_d      = 1'b1;
					pa_d      = rp_q;
				end else begin
					pv_d = 1'b0;
					// walk finished once the last read is consumed
					if (!pv_q) begin
						case (func_q)
							F_INSERT: begin
								state_d = S_INS_PUT;
							end
							F_DELETE: begin
								done_d  = 1'b1;
								data_d  = acc_q;
								cnt_d   = cnt_q - 1'b1;
								state_d = S_IDLE;
							end
							F_SEARCH, F_MOVE_FRONT: begin
								done_d   = 1'b1;
								data_d   = '0;
								pos_d    = '0;
								status_d = STAT_MISS;
								state_d  = S_IDLE;
							end
							default: begin
								done_d  = 1'b1;
								data_d  = acc_q;
								state_d = S_IDLE;
							end
						endcase
					end
				end
			end

			S_GET: begin
				alu_req.op = ALU_LOAD;
				data_d     = alu_res;
				done_d     = 1'b1;
				state_d    = S_IDLE;
			end

			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = val_q;
				cnt_d     = cnt_q + 1'b1;
				done_d    = 1'b1;
				state_d   = S_IDLE;
			end

			// move-front: old front entry goes to the match, key goes to the front
			S_MF_SWAP: begin
				mem_we    = 1'b1;
				mem_waddr = hit_q;
				mem_wdata = first_q;
				state_d   = S_MF_FRONT;
			end

			S_MF_FRONT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = val_q;
				done_d    = 1'b1;
				data_d    = acc_q;
				pos_d     = '0;
				status_d  = STAT_OK;
				state_d   = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// result ports
	assign pos_x    = XW'(pos_q);
	assign cnt_x    = XW'(cnt_q);
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign data     = data_q;
	assign position = pos_x[POS_W-1:0];
	assign status   = status_q;
	assign count    = cnt_x[CNT_W-1:0];

endmodule

// File: hdl/ale_alu.sv
module ale_alu (
	input  ale_pkg::alu_req_t                req,
	output logic signed [ale_pkg::DATA_W-1:0] res,
	output logic                              hit
);
	import ale_pkg::*;

	logic signed [DATA_W-1:0] opnd_x;

	// sign-extend the stored entry
	assign opnd_x = DATA_W'($signed(req.opnd));

	// equality against the search key held in the accumulator
	assign hit = (req.acc[VAL_W-1:0] == req.opnd);

	// one pass, load, compare or add per cycle
	always_comb begin
		case (req.op)
			ALU_PASS: res = req.acc;
			ALU_LOAD: res = opnd_x;
			ALU_MAX:  res = (opnd_x > req.acc) ? opnd_x : req.acc;
			ALU_MIN:  res = (opnd_x < req.acc) ? opnd_x : req.acc;
			ALU_ADD:  res = req.acc + opnd_x;
			default:  res = req.acc;
		endcase
	end

endmodule

// File: hdl/ale_mem.sv
module ale_mem #(
	parameter int DEPTH = ale_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [ale_pkg::VAL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [ale_pkg::VAL_W-1:0] rdata
);
	import ale_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: bench/array_list_engine_test.sv
`timescale 1ns / 100ps

module array_list_engine_test;

	import ale_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 150;
	localparam int RANDOM_ITEMS   = 1000;
	localparam int BATCH_LEN      = 16;
	localparam logic [IDX_W-1:0]  IDX_MAX = '1;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_W'(F_SUM + 1);
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = '1;
	localparam logic [VAL_W-1:0]  VAL_MAX = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0]  VAL_MIN = 32'h8000_0000;

	// shape of one batch of random operations
	typedef enum int {
		MODE_GROW,
		MODE_MIX,
		MODE_SHRINK,
		MODE_SATURATE
	} batch_mode_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  idx;
		logic [VAL_W-1:0]  val;
	} list_op_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         pos;
		logic [STAT_W-1:0]        stat;
		logic [CNT_W-1:0]         cnt;
	} list_reply_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     capacity_we;
	logic [CAP_W-1:0]         capacity_data;
	logic                     start;
	logic [FUNC_W-1:0]        func;
	logic [IDX_W-1:0]         index;
	logic signed [VAL_W-1:0]  value;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic [STAT_W-1:0]        status;
	logic [CNT_W-1:0]         count;

	// shadow of the list kept by the predictor
	logic [VAL_W-1:0] list_mem [DEPTH_DEF];
	int               list_len;
	int               list_cap;

	list_op_t    ops_to_send [$];
	list_reply_t replies_due [$];
	list_op_t    send_op;
	list_op_t    taken_op;
	list_reply_t got_reply;
	list_reply_t due_reply;
	bit          op_taken;
	int          burst_left;
	int          gap_left;
	int          idle_cycles;
	int          mismatch_count;
	int          ops_queued;

	array_list_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.capacity_we   (capacity_we),
		.capacity_data (capacity_data),
		.start         (start),
		.func          (func),
		.index         (index),
		.value         (value),
		.busy          (busy),
		.done          (done),
		.data          (data),
		.position      (position),
		.status        (status),
		.count         (count)
	);

	always #5 clk = ~clk;

	// predicted outcome of one operation on the shadow list
	function automatic list_reply_t list_apply(list_op_t op);
		list_reply_t              r;
		int                       n;
		int                       lim;
		int                       i;
		int                       hit;
		int                       at;
		logic signed [DATA_W-1:0] e;
		r = '0;
		n = list_len;
		at = int'(op.idx);
		lim = (list_cap > DEPTH_DEF) ? DEPTH_DEF : list_cap;
		case (op.func)
			F_APPEND: begin
				if (n >= lim) begin
					r.stat = STAT_BAD;
				end else begin
					list_mem[n] = op.val;
					list_len = n + 1;
				end
			end
			F_INSERT: begin
				if (n >= lim || at > n) begin
					r.stat = STAT_BAD;
				end else begin
					for (i = n; i > at; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[at] = op.val;
					list_len = n + 1;
				end
			end
			F_DELETE: begin
				if (at >= n) begin
					r.stat = STAT_BAD;
					r.data = DATA_NEG_ONE;
				end else begin
					r.data = DATA_W'($signed(list_mem[at]));
					for (i = at; i + 1 < n; i++)
						list_mem[i] = list_mem[i+1];
					list_len = n - 1;
				end
			end
			F_SEARCH, F_MOVE_FRONT: begin
				hit = -1;
				for (i = 0; i < n; i++)
					if (hit < 0 && list_mem[i] == op.val)
						hit = i;
				if (hit < 0) begin
					r.stat = STAT_MISS;
				end else begin
					r.data = DATA_W'($signed(op.val));
					if (op.func == F_MOVE_FRONT) begin
						list_mem[hit] = list_mem[0];
						list_mem[0] = op.val;
					end else begin
						r.pos = hit[POS_W-1:0];
					end
				end
			end
			F_GET: begin
				if (at >= n) begin
					r.stat = STAT_BAD;
					r.data = DATA_NEG_ONE;
				end else begin
					r.data = DATA_W'($signed(list_mem[at]));
				end
			end
			F_SET: begin
				if (at >= n)
					r.stat = STAT_BAD;
				else
					list_mem[at] = op.val;
			end
			F_MAX, F_MIN, F_SUM: begin
				if (n == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					r.data = DATA_W'($signed(list_mem[0]));
					for (i = 1; i < n; i++) begin
						e = DATA_W'($signed(list_mem[i]));
						if (op.func == F_MAX) begin
							if (e > r.data) r.data = e;
						end else if (op.func == F_MIN) begin
							if (e < r.data) r.data = e;
						end else begin
							r.data = r.data + e;
						end
					end
				end
			end
			default: ;
		endcase
		r.cnt = list_len[CNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
		if (got_v !== exp_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
		end
	endtask

	// driver: bursts of transactions separated by random gaps
	always @(negedge clk) begin
		if (arst_n && (!start || op_taken)) begin
			op_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (ops_to_send.size() > 0) begin
				send_op = ops_to_send.pop_front();
				func  <= send_op.func;
				index <= send_op.idx;
				value <= send_op.val;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: capacity writes, results, accepted transactions and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			if (capacity_we)
				list_cap = int'(capacity_data);
			if (done) begin
				got_reply = '{data, position, status, count};
				if (replies_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with none expected, data %0d status %0d",
						$time, data, status);
				end else begin
					due_reply = replies_due.pop_front();
					check_field("data", due_reply.data, got_reply.data);
					check_field("position", DATA_W'(due_reply.pos), DATA_W'(got_reply.pos));
					check_field("status", DATA_W'(due_reply.stat), DATA_W'(got_reply.stat));
					check_field("count", DATA_W'(due_reply.cnt), DATA_W'(got_reply.cnt));
				end
			end
			if (start && !busy) begin
				taken_op = '{func, index, value};
				replies_due.push_back(list_apply(taken_op));
				op_taken = 1'b1;
			end
		end
	end

	task automatic queue_op(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] i, logic [VAL_W-1:0] v);
		ops_to_send.push_back('{f, i, v});
		ops_queued++;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (ops_to_send.size() != 0 || replies_due.size() != 0 || start)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		@(negedge clk);
		capacity_we   <= 1'b1;
		capacity_data <= cap;
		@(negedge clk);
		capacity_we   <= 1'b0;
		@(posedge clk);
	endtask

	// values: extremes, entries already in the list, small repeats, random
	function automatic logic [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			case ($urandom_range(0, 3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return '0;
				default: return '1;
			endcase
		end
		if (r < 45 && list_len > 0)
			return list_mem[$urandom_range(0, list_len - 1)];
		if (r < 60)
			return $urandom_range(0, 7);
		return $urandom;
	endfunction

	// indexes: mostly legal, with the edges and the whole field range
	function automatic logic [IDX_W-1:0] pick_index(int guess);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return IDX_W'($urandom_range(0, (guess > 0) ? guess - 1 : 0));
		if (r < 80)
			return IDX_W'(guess);
		if (r < 85)
			return IDX_W'(guess + 1);
		return IDX_W'($urandom_range(0, IDX_MAX));
	endfunction

	task automatic plan_batch(batch_mode_t mode);
		int                guess;
		int                k;
		int                r;
		logic [FUNC_W-1:0] f;
		logic [VAL_W-1:0]  fill_val;
		guess = list_len;
		if (mode == MODE_SATURATE) begin
			// empty the list, refill it with one extreme, then reduce it
			fill_val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			for (k = 0; k < list_len; k++)
				queue_op(F_DELETE, '0, pick_value());
			for (k = 0; k < DEPTH_DEF; k++)
				queue_op(F_APPEND, pick_index(k), fill_val);
			queue_op(F_SUM, '0, '0);
			queue_op(F_MAX, '0, '0);
			queue_op(F_MIN, '0, '0);
			queue_op(F_INSERT, IDX_W'($urandom_range(0, DEPTH_DEF)), fill_val);
			queue_op(F_MOVE_FRONT, '0, fill_val);
			return;
		end
		for (k = 0; k < BATCH_LEN; k++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				f = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
			else if (mode == MODE_GROW && r < 70)
				f = F_APPEND;
			else if (mode == MODE_GROW && r < 85)
				f = F_INSERT;
			else if (mode == MODE_SHRINK && r < 65)
				f = F_DELETE;
			else
				f = FUNC_W'($urandom_range(F_APPEND, F_SUM));
			queue_op(f, pick_index(guess), pick_value());
			if ((f == F_APPEND || f == F_INSERT) && guess < DEPTH_DEF)
				guess++;
			else if (f == F_DELETE && guess > 0)
				guess--;
		end
	endtask

	// stimulus
	initial begin
		int          batches;
		int          r;
		batch_mode_t mode;
		arst_n = 1'b0;
		capacity_we = 1'b0;
		capacity_data = '0;
		start = 1'b0;
		func = '0;
		index = '0;
		value = '0;
		op_taken = 1'b0;
		burst_left = 1;
		gap_left = 0;
		idle_cycles = 0;
		mismatch_count = 0;
		ops_queued = 0;
		list_len = 0;
		list_cap = int'(CAP_RESET);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, edges of insert/get/delete, searches, unused codes
		queue_op(F_SUM, '0, '0);
		queue_op(F_MAX, '0, '0);
		queue_op(F_MIN, '0, '0);
		queue_op(F_DELETE, '0, '0);
		queue_op(F_GET, '0, '0);
		queue_op(F_SET, '0, 32'h1234_5678);
		queue_op(F_SEARCH, '0, '0);
		queue_op(F_MOVE_FRONT, '0, '0);
		queue_op(F_INSERT, 7'd1, 32'd5);
		queue_op(F_INSERT, '0, VAL_MAX);
		queue_op(F_APPEND, '0, VAL_MIN);
		queue_op(F_INSERT, 7'd1, '1);
		queue_op(F_INSERT, 7'd3, '0);
		queue_op(F_GET, 7'd3, '0);
		queue_op(F_GET, 7'd4, '0);
		queue_op(F_SEARCH, '0, VAL_MIN);
		queue_op(F_MOVE_FRONT, '0, '0);
		queue_op(F_MAX, '0, '0);
		queue_op(F_MIN, '0, '0);
		queue_op(F_SUM, '0, '0);
		queue_op(F_SET, 7'd1, 32'h5a5a_5a5a);
		queue_op(F_SET, 7'd4, 32'ha5a5_a5a5);
		queue_op(F_DELETE, '0, '0);
		queue_op(F_DELETE, 7'd2, '0);
		queue_op(F_DELETE, IDX_MAX, '0);
		queue_op(FUNC_SPARE_FIRST, '0, '0);
		queue_op(FUNC_SPARE_LAST, IDX_MAX, '1);
		wait_drained();

		// capacity lowered below the count, then zero, then the top of the field
		write_capacity(7'd1);
		queue_op(F_APPEND, '0, 32'd7);
		queue_op(F_INSERT, '0, 32'd7);
		wait_drained();
		write_capacity('0);
		queue_op(F_APPEND, '0, 32'd9);
		queue_op(F_GET, '0, '0);
		wait_drained();
		write_capacity('1);

		// random batches with capacity changes between them
		batches = 0;
		ops_queued = 0;
		while (ops_queued < RANDOM_ITEMS) begin
			if (batches % 6 == 5) begin
				wait_drained();
				r = $urandom_range(0, 99);
				if (r < 60)
					write_capacity(CAP_W'($urandom_range(DEPTH_DEF, (1 << CAP_W) - 1)));
				else if (r < 70)
					write_capacity('0);
				else if (r < 80)
					write_capacity(7'd1);
				else
					write_capacity(CAP_W'($urandom_range(0, DEPTH_DEF - 1)));
			end
			r = $urandom_range(0, 99);
			if (list_len < 8)
				mode = (r < 60) ? MODE_GROW : (r < 90) ? MODE_MIX : MODE_SATURATE;
			else if (list_len > 52)
				mode = (r < 50) ? MODE_SHRINK : MODE_MIX;
			else
				mode = (r < 25) ? MODE_GROW : (r < 45) ? MODE_SHRINK :
					(r < 50) ? MODE_SATURATE : MODE_MIX;
			plan_batch(mode);
			batches++;
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && replies_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
